[src/aavr_pkg.sv]
// Shared types, constants and helpers for the axis-angle vector rotator.
package aavr_pkg;

  localparam int CordicSteps = 16;
  localparam int HalfTurn = 46080;
  localparam int QuarterTurn = 23040;
  localparam int FullTurn = 92160;
  localparam logic signed [31:0] CordicGain = 32'sd652032874;

  typedef struct packed {
    logic signed [16:0] angle_deg;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } out_req_t;

  // Quaternion plus the vector it acts on; axis terms reach +2^25 for a
  // full-scale negative axis component
  typedef struct packed {
    logic signed [26:0] qw;
    logic signed [26:0] qx;
    logic signed [26:0] qy;
    logic signed [26:0] qz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } quat_req_t;

  // arctangent of 2^-i in degrees, Q.16
  function automatic logic signed [24:0] atan_deg(input logic [3:0] i);
    case (i)
      4'd0: atan_deg = 25'sd2949120;
      4'd1: atan_deg = 25'sd1740967;
      4'd2: atan_deg = 25'sd919879;
      4'd3: atan_deg = 25'sd466945;
      4'd4: atan_deg = 25'sd234379;
      4'd5: atan_deg = 25'sd117304;
      4'd6: atan_deg = 25'sd58666;
      4'd7: atan_deg = 25'sd29335;
      4'd8: atan_deg = 25'sd14668;
      4'd9: atan_deg = 25'sd7334;
      4'd10: atan_deg = 25'sd3667;
      4'd11: atan_deg = 25'sd1833;
      4'd12: atan_deg = 25'sd917;
      4'd13: atan_deg = 25'sd458;
      4'd14: atan_deg = 25'sd229;
      default: atan_deg = 25'sd115;
    endcase
  endfunction

endpackage

[src/aavr_cordic.sv]
// Pipelined CORDIC: half-angle sine and cosine, then quaternion build.
module aavr_cordic import aavr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_vld,
  input  in_req_t   in_req,
  output logic      out_vld,
  output quat_req_t out_quat
);

  localparam int NS = CordicSteps + 1;

  logic              vld_r [NS];
  logic signed [32:0] x_r [NS];
  logic signed [32:0] y_r [NS];
  logic signed [24:0] z_r [NS];
  logic              neg_r [NS];
  in_req_t           d_r [NS];
  logic signed [17:0] a0, a1;
  logic              neg0;
  logic signed [32:0] qs, qc;
  logic signed [49:0] px, py, pz;
  quat_req_t         q_r;
  logic              qv_r;

  // fold the angle into [-90,90] degrees
  always_comb begin
    a0 = 18'(in_req.angle_deg);
    if (a0 > 18'(HalfTurn)) a0 = a0 - 18'(FullTurn);
    if (a0 < -18'(HalfTurn)) a0 = a0 + 18'(FullTurn);
    neg0 = 1'b0;
    a1 = a0;
    if (a0 > 18'(QuarterTurn)) begin
      a1 = a0 - 18'(HalfTurn);
      neg0 = 1'b1;
    end else if (a0 < -18'(QuarterTurn)) begin
      a1 = a0 + 18'(HalfTurn);
      neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
    end
    if (adv) begin
      x_r[0] <= 33'(CordicGain);
      y_r[0] <= '0;
      z_r[0] <= {a1[16:0], 8'd0};
      neg_r[0] <= neg0;
      d_r[0] <= in_req;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (adv) begin
        neg_r[i+1] <= neg_r[i];
        d_r[i+1] <= d_r[i];
        if (!z_r[i][24]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_deg(4'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_deg(4'(i));
        end
      end
    end
  end

  // sign fix and axis scaling
  assign qs = neg_r[CordicSteps] ? -y_r[CordicSteps] : y_r[CordicSteps];
  assign qc = neg_r[CordicSteps] ? -x_r[CordicSteps] : x_r[CordicSteps];
  assign px = 50'(d_r[CordicSteps].axis_x) * 50'(qs) + 50'sd524288;
  assign py = 50'(d_r[CordicSteps].axis_y) * 50'(qs) + 50'sd524288;
  assign pz = 50'(d_r[CordicSteps].axis_z) * 50'(qs) + 50'sd524288;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r <= 1'b0;
    end else if (adv) begin
      qv_r <= vld_r[CordicSteps];
    end
    if (adv) begin
      q_r.qw <= 27'((qc + 33'sd32) >>> 6);
      q_r.qx <= 27'(px >>> 20);
      q_r.qy <= 27'(py >>> 20);
      q_r.qz <= 27'(pz >>> 20);
      q_r.vx <= d_r[CordicSteps].vec_x;
      q_r.vy <= d_r[CordicSteps].vec_y;
      q_r.vz <= d_r[CordicSteps].vec_z;
    end
  end

  assign out_vld = qv_r;
  assign out_quat = q_r;

endmodule

[src/aavr_hamilton.sv]
// Two pipelined Hamilton products q*v*conj(q) with rounding and saturation.
module aavr_hamilton import aavr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_vld,
  input  quat_req_t in_quat,
  output logic      out_vld,
  output out_req_t  out_rot
);

  localparam logic signed [63:0] Half24 = 64'sd8388608;

  // stage A: products of q and v
  logic signed [57:0] ma_r [12];
  logic signed [26:0] qa_r [4];
  logic               va_r;
  // stage B: first product rounded, magnitude below 3*2^32
  logic signed [35:0] p_r [4];
  logic signed [26:0] qb_r [4];
  logic               vb_r;
  // stage C: products of p and conj(q)
  logic signed [67:0] mc_r [12];
  logic               vc_r;
  // stage D: result
  out_req_t           o_r;
  logic               vd_r;

  logic signed [63:0] sw, sx, sy, sz;
  logic signed [69:0] rx, ry, rz;

  function automatic logic signed [31:0] sat(input logic signed [69:0] v);
    if (v > 70'sd2147483647) sat = 32'sh7fffffff;
    else if (v < -70'sd2147483648) sat = 32'sh80000000;
    else sat = v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_vld;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma_r[0] <= 58'(in_quat.qx) * 58'(in_quat.vx);
      ma_r[1] <= 58'(in_quat.qy) * 58'(in_quat.vy);
      ma_r[2] <= 58'(in_quat.qz) * 58'(in_quat.vz);
      ma_r[3] <= 58'(in_quat.qw) * 58'(in_quat.vx);
      ma_r[4] <= 58'(in_quat.qy) * 58'(in_quat.vz);
      ma_r[5] <= 58'(in_quat.qz) * 58'(in_quat.vy);
      ma_r[6] <= 58'(in_quat.qw) * 58'(in_quat.vy);
      ma_r[7] <= 58'(in_quat.qz) * 58'(in_quat.vx);
      ma_r[8] <= 58'(in_quat.qx) * 58'(in_quat.vz);
      ma_r[9] <= 58'(in_quat.qw) * 58'(in_quat.vz);
      ma_r[10] <= 58'(in_quat.qx) * 58'(in_quat.vy);
      ma_r[11] <= 58'(in_quat.qy) * 58'(in_quat.vx);
      qa_r[0] <= in_quat.qw;
      qa_r[1] <= in_quat.qx;
      qa_r[2] <= in_quat.qy;
      qa_r[3] <= in_quat.qz;
    end
  end

  // sums of the first product
  assign sw = -64'(ma_r[0]) - 64'(ma_r[1]) - 64'(ma_r[2]) + Half24;
  assign sx = 64'(ma_r[3]) + 64'(ma_r[4]) - 64'(ma_r[5]) + Half24;
  assign sy = 64'(ma_r[6]) + 64'(ma_r[7]) - 64'(ma_r[8]) + Half24;
  assign sz = 64'(ma_r[9]) + 64'(ma_r[10]) - 64'(ma_r[11]) + Half24;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= 36'(sw >>> 24);
      p_r[1] <= 36'(sx >>> 24);
      p_r[2] <= 36'(sy >>> 24);
      p_r[3] <= 36'(sz >>> 24);
      qb_r <= qa_r;
    end
  end

  // p = (w,x,y,z) at index 0..3; q likewise
  always_ff @(posedge clk) begin
    if (adv) begin
      mc_r[0] <= 68'(p_r[1]) * 68'(qb_r[0]);
      mc_r[1] <= 68'(p_r[0]) * 68'(qb_r[1]);
      mc_r[2] <= 68'(p_r[2]) * 68'(qb_r[3]);
      mc_r[3] <= 68'(p_r[3]) * 68'(qb_r[2]);
      mc_r[4] <= 68'(p_r[2]) * 68'(qb_r[0]);
      mc_r[5] <= 68'(p_r[0]) * 68'(qb_r[2]);
      mc_r[6] <= 68'(p_r[3]) * 68'(qb_r[1]);
      mc_r[7] <= 68'(p_r[1]) * 68'(qb_r[3]);
      mc_r[8] <= 68'(p_r[3]) * 68'(qb_r[0]);
      mc_r[9] <= 68'(p_r[0]) * 68'(qb_r[3]);
      mc_r[10] <= 68'(p_r[1]) * 68'(qb_r[2]);
      mc_r[11] <= 68'(p_r[2]) * 68'(qb_r[1]);
    end
  end

  assign rx = (70'(mc_r[0]) - 70'(mc_r[1]) - 70'(mc_r[2]) + 70'(mc_r[3])
               + 70'sd8388608) >>> 24;
  assign ry = (70'(mc_r[4]) - 70'(mc_r[5]) - 70'(mc_r[6]) + 70'(mc_r[7])
               + 70'sd8388608) >>> 24;
  assign rz = (70'(mc_r[8]) - 70'(mc_r[9]) - 70'(mc_r[10]) + 70'(mc_r[11])
               + 70'sd8388608) >>> 24;

  always_ff @(posedge clk) begin
    if (adv) begin
      o_r.rot_x <= sat(rx);
      o_r.rot_y <= sat(ry);
      o_r.rot_z <= sat(rz);
    end
  end

  assign out_vld = vd_r;
  assign out_rot = o_r;

endmodule

[src/axis_angle_vector_rotate.sv]
// Top level: axis-angle vector rotator, CORDIC then quaternion products.
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall  | in_req_t  (angle, axis, vector)
//  out_    | out | out_valid/out_stall| out_req_t (rotated vector)
// One request per cycle unless the output stalls; stages: 17 CORDIC/fold,
// 1 quaternion, 3 product, 1 output. A stall on the output freezes the whole
// pipe unless the output register is empty; nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits.
module axis_angle_vector_rotate import aavr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_req
);

  logic      adv, qv, hv;
  quat_req_t quat;
  out_req_t  rot;

  // pipe advances whenever the output slot is free or being taken
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  aavr_cordic u_cordic (
    .clk, .rst_n, .adv, .in_vld(in_valid), .in_req,
    .out_vld(qv), .out_quat(quat)
  );

  aavr_hamilton u_ham (
    .clk, .rst_n, .adv, .in_vld(qv), .in_quat(quat),
    .out_vld(hv), .out_rot(rot)
  );

  assign out_valid = hv;
  assign out_req = rot;

endmodule

[src/aavr_checker.sv]
// Port-level checker for the rotator, bound to the top level.
module aavr_checker import aavr_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_req_t out_req
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_req))
    else $error("stalled result changed");

  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid after reset");

endmodule

bind axis_angle_vector_rotate aavr_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_req
);
